[rtl/nva_pkg.sv]
// ----------------------------------------------------------------------------
// nva_pkg
// Shared types and constants for the notification value allocator.
// ----------------------------------------------------------------------------
package nva_pkg;

  localparam int VALUE_COUNT_DEF = 64;
  localparam int VALUE_W         = 6;
  localparam int MODE_W          = 2;
  localparam int STATUS_W        = 2;

  localparam logic [MODE_W-1:0] MODE_ALLOC = 2'd0;
  localparam logic [MODE_W-1:0] MODE_FREE  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_SEND  = 2'd2;
  localparam logic [MODE_W-1:0] MODE_FETCH = 2'd3;

  localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_FULL    = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_BADFREE = 2'd2;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic exec;
  } ctrl_t;

  // datapath to controller
  typedef struct packed {
    logic out_busy;
  } dp_stat_t;

endpackage

[rtl/nva_ifs.sv]
// ----------------------------------------------------------------------------
// nva interfaces
// Request, response and configuration channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface nva_req_if import nva_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [MODE_W-1:0]  mode;
  logic [VALUE_W-1:0] value;
  modport source (output valid, mode, value, input ready);
  modport sink   (input valid, mode, value, output ready);
endinterface

interface nva_rsp_if import nva_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [VALUE_W-1:0]  result_value;
  logic                fetch_hit;
  logic                more_pending;
  logic                raise_interrupt;
  modport source (output valid, status, result_value, fetch_hit, more_pending,
                  raise_interrupt, input ready);
  modport sink   (input valid, status, result_value, fetch_hit, more_pending,
                  raise_interrupt, output ready);
endinterface

interface nva_cfg_if import nva_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [VALUE_W-1:0] reserved_value;
  modport source (output valid, reserved_value, input ready);
  modport sink   (input valid, reserved_value, output ready);
endinterface

[rtl/notification_value_allocator_unit.sv]
// ----------------------------------------------------------------------------
// notification_value_allocator_unit
// Allocation and pending bitmaps over notification values with allocate,
// free, send and fetch operations.
// ----------------------------------------------------------------------------
//  channel | dir | beat payload
//  req     | in  | mode, value
//  rsp     | out | status, result_value, fetch_hit, more_pending,
//          |     | raise_interrupt
//  cfg     | in  | reserved_value (always ready)
//
//  each request first has its beat captured, then is searched and updates the
//  bitmaps into the response register
//  a new request is taken while the previous response still waits
//  execution stalls while the response register is full and not taken
//  rst clears both bitmaps, the reserved flag and the reserved value
// ----------------------------------------------------------------------------
module notification_value_allocator_unit import nva_pkg::*; #(
  parameter int VALUE_COUNT = VALUE_COUNT_DEF
) (
  input  logic      clk,
  input  logic      rst,
  nva_req_if.sink   req,
  nva_rsp_if.source rsp,
  nva_cfg_if.sink   cfg
);

  ctrl_t    ctrl;
  dp_stat_t stat;

  nva_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .stat      (stat),
    .ctrl      (ctrl)
  );

  nva_dp #(
    .VALUE_COUNT (VALUE_COUNT)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (ctrl),
    .stat      (stat),
    .req_mode  (req.mode),
    .req_value (req.value),
    .cfg       (cfg),
    .rsp       (rsp)
  );

endmodule

[rtl/nva_ctrl.sv]
// ----------------------------------------------------------------------------
// nva_ctrl
// Two-state controller: takes a request beat, then runs it once the
// response register is free.
// ----------------------------------------------------------------------------
module nva_ctrl import nva_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     req_valid,
  output logic     req_ready,
  input  dp_stat_t stat,
  output ctrl_t    ctrl
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    req_ready  = 1'b0;
    ctrl.load  = 1'b0;
    ctrl.exec  = 1'b0;
    case (state)
      S_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          ctrl.load  = 1'b1;
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        if (!stat.out_busy) begin
          ctrl.exec  = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

[rtl/nva_dp.sv]
// ----------------------------------------------------------------------------
// nva_dp
// Bitmaps, reserved value register, lowest-bit search and response register.
// ----------------------------------------------------------------------------
module nva_dp import nva_pkg::*; #(
  parameter int VALUE_COUNT = VALUE_COUNT_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  ctrl_t              ctrl,
  output dp_stat_t           stat,
  input  logic [MODE_W-1:0]  req_mode,
  input  logic [VALUE_W-1:0] req_value,
  nva_cfg_if.sink            cfg,
  nva_rsp_if.source          rsp
);

  localparam int VC = VALUE_COUNT;

  logic [VC-1:0]      allocated_map;
  logic [VC-1:0]      pending_map;
  logic               reserved_marked;
  logic [VALUE_W-1:0] reserved_value;
  logic [MODE_W-1:0]  mode;
  logic [VALUE_W-1:0] value;
  logic               out_valid;

  logic [VC-1:0]      one;
  logic               val_in_range;
  logic               res_in_range;
  logic [VC-1:0]      val_bit;
  logic [VC-1:0]      res_bit;
  logic [VC-1:0]      alloc_eff;
  logic [VC-1:0]      free_bits;
  logic [VC-1:0]      free_low;
  logic [VC-1:0]      pend_low;
  logic [VALUE_W-1:0] free_idx;
  logic [VALUE_W-1:0] pend_idx;

  logic [STATUS_W-1:0] status_next;
  logic [VALUE_W-1:0]  result_value_next;
  logic                fetch_hit_next;
  logic                more_pending_next;
  logic                raise_interrupt_next;

  assign one          = {{(VC-1){1'b0}}, 1'b1};
  assign val_in_range = {1'b0, value} < (VALUE_W+1)'(VC);
  assign res_in_range = {1'b0, reserved_value} < (VALUE_W+1)'(VC);
  assign val_bit      = val_in_range ? (one << value) : '0;
  assign res_bit      = (!reserved_marked && res_in_range) ? (one << reserved_value) : '0;
  assign alloc_eff    = allocated_map | res_bit;
  assign free_bits    = ~alloc_eff;
  // isolate lowest set bit
  assign free_low     = free_bits & (~free_bits + one);
  assign pend_low     = pending_map & (~pending_map + one);

  always_comb begin
    free_idx = '0;
    pend_idx = '0;
    for (int i = 0; i < VC; i++) begin
      if (free_low[i]) free_idx = free_idx | VALUE_W'(i);
      if (pend_low[i]) pend_idx = pend_idx | VALUE_W'(i);
    end
  end

  assign cfg.ready     = 1'b1;
  assign stat.out_busy = out_valid && !rsp.ready;
  assign rsp.valid     = out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      reserved_value <= '0;
    end else if (cfg.valid) begin
      reserved_value <= cfg.reserved_value;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      mode  <= req_mode;
      value <= req_value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      allocated_map   <= '0;
      pending_map     <= '0;
      reserved_marked <= 1'b0;
      out_valid       <= 1'b0;
    end else begin
      if (ctrl.exec) begin
        out_valid <= 1'b1;
        case (mode)
          MODE_ALLOC: begin
            reserved_marked <= 1'b1;
            allocated_map   <= alloc_eff | free_low;
          end
          MODE_FREE: begin
            allocated_map <= allocated_map & ~val_bit;
          end
          MODE_SEND: begin
            pending_map <= pending_map | val_bit;
          end
          MODE_FETCH: begin
            pending_map <= pending_map & ~pend_low;
          end
          default: begin
            pending_map <= pending_map;
          end
        endcase
      end else if (rsp.valid && rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_comb begin
    status_next          = STATUS_OK;
    result_value_next    = '0;
    fetch_hit_next       = 1'b0;
    more_pending_next    = 1'b0;
    raise_interrupt_next = 1'b0;
    case (mode)
      MODE_ALLOC: begin
        if (free_bits == '0) begin
          status_next = STATUS_FULL;
        end else begin
          result_value_next = free_idx;
        end
      end
      MODE_FREE: begin
        if ((allocated_map & val_bit) == '0) begin
          status_next = STATUS_BADFREE;
        end
      end
      MODE_SEND: begin
        raise_interrupt_next = val_in_range;
      end
      MODE_FETCH: begin
        if (pending_map != '0) begin
          result_value_next = pend_idx;
          fetch_hit_next    = 1'b1;
          more_pending_next = (pending_map & ~pend_low) != '0;
        end
      end
      default: begin
        status_next = STATUS_OK;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (ctrl.exec) begin
      rsp.status          <= status_next;
      rsp.result_value    <= result_value_next;
      rsp.fetch_hit       <= fetch_hit_next;
      rsp.more_pending    <= more_pending_next;
      rsp.raise_interrupt <= raise_interrupt_next;
    end
  end

endmodule

[bench/notification_value_allocator_unit_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// notification_value_allocator_unit_tb
// Drives allocate, free, send and fetch beats into the allocator under random
// idling on both channels, predicts every response from its own copy of the
// allocation and pending bitmaps, and compares each response field by field.
// ----------------------------------------------------------------------------
import nva_pkg::*;

typedef struct packed {
  logic [STATUS_W-1:0] status;
  logic [VALUE_W-1:0]  result_value;
  logic                fetch_hit;
  logic                more_pending;
  logic                raise_interrupt;
} reply_t;

class allocator_model;
  logic [63:0]        alloc_map;
  logic [63:0]        pend_map;
  bit                 reserved_marked;
  logic [VALUE_W-1:0] reserved_value;
  reply_t             expected_replies[$];
  int                 mismatches;

  function new();
    alloc_map       = '0;
    pend_map        = '0;
    reserved_marked = 1'b0;
    reserved_value  = '0;
    mismatches      = 0;
  endfunction

  function void set_reserved(logic [VALUE_W-1:0] v);
    reserved_value = v;
  endfunction

  function int lowest_set(logic [63:0] bits);
    for (int i = 0; i < VALUE_COUNT_DEF; i++) begin
      if (bits[i]) return i;
    end
    return -1;
  endfunction

  function void note_op(logic [MODE_W-1:0] mode, logic [VALUE_W-1:0] value);
    reply_t r;
    int     pos;
    bit     in_range;
    r = '0;
    in_range = (int'(value) < VALUE_COUNT_DEF);
    case (mode)
      MODE_ALLOC: begin
        if (!reserved_marked) begin
          if (int'(reserved_value) < VALUE_COUNT_DEF) alloc_map[reserved_value] = 1'b1;
          reserved_marked = 1'b1;
        end
        pos = lowest_set(~alloc_map);
        if (pos < 0) begin
          r.status = STATUS_FULL;
        end else begin
          r.result_value = pos[VALUE_W-1:0];
          alloc_map[pos] = 1'b1;
        end
      end
      MODE_FREE: begin
        if (in_range && alloc_map[value]) alloc_map[value] = 1'b0;
        else r.status = STATUS_BADFREE;
      end
      MODE_SEND: begin
        if (in_range) begin
          pend_map[value]   = 1'b1;
          r.raise_interrupt = 1'b1;
        end
      end
      default: begin
        pos = lowest_set(pend_map);
        if (pos >= 0) begin
          r.result_value = pos[VALUE_W-1:0];
          r.fetch_hit    = 1'b1;
          pend_map[pos]  = 1'b0;
          r.more_pending = (lowest_set(pend_map) >= 0);
        end
      end
    endcase
    expected_replies.push_back(r);
  endfunction

  task report_mismatch(string what, int got, int want);
    $display("%0t mismatch %s: got %0d expected %0d", $time, what, got, want);
    mismatches++;
  endtask

  task check_reply(reply_t got);
    reply_t want;
    if (expected_replies.size() == 0) begin
      report_mismatch("response beat with nothing outstanding", 1, 0);
      return;
    end
    want = expected_replies.pop_front();
    if (got.status !== want.status)
      report_mismatch("status", got.status, want.status);
    if (got.result_value !== want.result_value)
      report_mismatch("result_value", got.result_value, want.result_value);
    if (got.fetch_hit !== want.fetch_hit)
      report_mismatch("fetch_hit", got.fetch_hit, want.fetch_hit);
    if (got.more_pending !== want.more_pending)
      report_mismatch("more_pending", got.more_pending, want.more_pending);
    if (got.raise_interrupt !== want.raise_interrupt)
      report_mismatch("raise_interrupt", got.raise_interrupt, want.raise_interrupt);
  endtask
endclass

module notification_value_allocator_unit_tb;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int SETTLE_CYCLES = 8;
  localparam int PHASE_OPS     = 270;

  typedef enum int {BURST_FILL, BURST_DRAIN, BURST_NOTIFY, BURST_NOISE} burst_kind_t;

  logic clk;
  logic rst;

  nva_req_if req_if ();
  nva_rsp_if rsp_if ();
  nva_cfg_if cfg_if ();

  notification_value_allocator_unit #(.VALUE_COUNT(VALUE_COUNT_DEF)) dut (
    .clk (clk),
    .rst (rst),
    .req (req_if),
    .rsp (rsp_if),
    .cfg (cfg_if)
  );

  allocator_model model;
  int send_idle_pct;
  int rcv_idle_pct;
  int ops_sent;
  int cycle_count;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(negedge clk) begin
    rsp_if.ready <= ($urandom_range(0, 99) >= rcv_idle_pct);
  end

  always @(posedge clk) begin
    reply_t got;
    if (!rst) begin
      if (cfg_if.valid && cfg_if.ready) model.set_reserved(cfg_if.reserved_value);
      if (req_if.valid && req_if.ready) model.note_op(req_if.mode, req_if.value);
      if (rsp_if.valid && rsp_if.ready) begin
        got.status          = rsp_if.status;
        got.result_value    = rsp_if.result_value;
        got.fetch_hit       = rsp_if.fetch_hit;
        got.more_pending    = rsp_if.more_pending;
        got.raise_interrupt = rsp_if.raise_interrupt;
        model.check_reply(got);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL notification_value_allocator_unit");
      $finish;
    end
  end

  function automatic logic [VALUE_W-1:0] any_value();
    return VALUE_W'($urandom_range(0, 63));
  endfunction

  function automatic logic [VALUE_W-1:0] pick_allocated();
    int start;
    int idx;
    start = $urandom_range(0, 63);
    for (int i = 0; i < 64; i++) begin
      idx = (start + i) % 64;
      if (model.alloc_map[idx]) return VALUE_W'(idx);
    end
    return any_value();
  endfunction

  task automatic send_op(logic [MODE_W-1:0] m, logic [VALUE_W-1:0] v);
    @(negedge clk);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      req_if.valid <= 1'b0;
      @(negedge clk);
    end
    req_if.valid <= 1'b1;
    req_if.mode  <= m;
    req_if.value <= v;
    @(posedge clk);
    while (!req_if.ready) @(posedge clk);
    ops_sent++;
  endtask

  // drop valid and hold off until every response is back
  task automatic wait_drained();
    @(negedge clk);
    req_if.valid <= 1'b0;
    while (model.expected_replies.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reserved(logic [VALUE_W-1:0] v);
    @(negedge clk);
    cfg_if.valid          <= 1'b1;
    cfg_if.reserved_value <= v;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    @(negedge clk);
    cfg_if.valid <= 1'b0;
  endtask

  task automatic run_directed();
    logic [VALUE_W-1:0] v;
    send_op(MODE_FETCH, 6'h3f);
    send_op(MODE_FREE, 6'h00);
    send_op(MODE_FREE, 6'h3f);
    send_op(MODE_SEND, 6'h00);
    send_op(MODE_SEND, 6'h3f);
    send_op(MODE_SEND, 6'h00);
    send_op(MODE_FETCH, 6'h00);
    send_op(MODE_FETCH, 6'h00);
    send_op(MODE_FETCH, 6'h00);
    send_op(MODE_ALLOC, 6'h3f);
    send_op(MODE_ALLOC, 6'h00);
    send_op(MODE_ALLOC, 6'h15);
    wait_drained();
    v = pick_allocated();
    send_op(MODE_FREE, v);
    send_op(MODE_FREE, v);
    send_op(MODE_ALLOC, 6'h2a);
    send_op(MODE_SEND, 6'h1f);
    send_op(MODE_SEND, 6'h20);
    send_op(MODE_FETCH, 6'h3f);
    send_op(MODE_FETCH, 6'h00);
    send_op(MODE_FETCH, 6'h00);
  endtask

  task automatic run_random(int budget);
    int          start;
    int          n;
    bit          first;
    burst_kind_t kind;
    start = ops_sent;
    first = 1'b1;
    while (ops_sent - start < budget) begin
      kind  = first ? BURST_FILL : burst_kind_t'($urandom_range(0, 3));
      first = 1'b0;
      case (kind)
        BURST_FILL: begin
          repeat (72) send_op(MODE_ALLOC, any_value());
        end
        BURST_DRAIN: begin
          repeat (48) begin
            send_op(MODE_FREE, ($urandom_range(0, 99) < 80) ? pick_allocated() : any_value());
          end
        end
        BURST_NOTIFY: begin
          n = $urandom_range(1, 24);
          repeat (n) send_op(MODE_SEND, any_value());
          repeat (n + 2) send_op(MODE_FETCH, any_value());
        end
        default: begin
          repeat (32) send_op(MODE_W'($urandom_range(0, 3)), any_value());
        end
      endcase
      if ($urandom_range(0, 9) == 0) wait_drained();
    end
  endtask

  initial begin
    logic [VALUE_W-1:0] first_reserved;
    model                 = new();
    rst                   = 1'b1;
    req_if.valid          = 1'b0;
    req_if.mode           = MODE_ALLOC;
    req_if.value          = '0;
    rsp_if.ready          = 1'b0;
    cfg_if.valid          = 1'b0;
    cfg_if.reserved_value = '0;
    send_idle_pct         = 38;
    rcv_idle_pct          = 86;
    ops_sent              = 0;
    cycle_count           = 0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    case ($urandom_range(0, 2))
      0:       first_reserved = 6'h00;
      1:       first_reserved = 6'h3f;
      default: first_reserved = any_value();
    endcase
    write_reserved(6'h3f);
    write_reserved(first_reserved);
    run_directed();
    run_random(PHASE_OPS);

    wait_drained();
    write_reserved(6'h00);
    send_idle_pct = 86;
    rcv_idle_pct  = 38;
    run_random(PHASE_OPS);

    wait_drained();
    write_reserved(6'h3f);
    write_reserved(any_value());
    send_idle_pct = 0;
    rcv_idle_pct  = 0;
    run_random(PHASE_OPS);

    wait_drained();
    if (model.mismatches == 0) begin
      $display("PASS notification_value_allocator_unit");
    end else begin
      $display("FAIL notification_value_allocator_unit");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/nva_pkg.sv
rtl/nva_ifs.sv
rtl/nva_ctrl.sv
rtl/nva_dp.sv
rtl/notification_value_allocator_unit.sv
bench/notification_value_allocator_unit_tb.sv
